[sv/iqpd_pkg.sv]
`default_nettype none

package iqpd_pkg;

    typedef struct packed {
        logic signed [11:0] i_sample;
        logic signed [11:0] q_sample;
    } t_sample;

    typedef struct packed {
        logic signed [15:0] average_dbm;
        logic               detected;
    } t_result;

    // register map, index taken from paddr[2]
    localparam logic REG_BLOCK_LENGTH     = 1'b0;
    localparam logic REG_DETECT_THRESHOLD = 1'b1;

    localparam logic        [12:0] BLOCK_LENGTH_RST     = 13'd1600;
    localparam logic signed [15:0] DETECT_THRESHOLD_RST = 16'sd1664;

    // q8 db arithmetic
    localparam logic        [15:0] DB_PER_OCTAVE  = 16'd771;
    localparam logic        [15:0] DBM_OFFSET     = 16'd15438;
    localparam logic signed [15:0] ZERO_POWER_DBM = -16'sd17920;

    localparam int QUEUE_DEPTH = 4;

    // round(2560*log10(1+k/64))
    localparam logic [9:0] LOGTAB [64] = '{
        10'd0,   10'd17,  10'd34,  10'd51,  10'd67,  10'd84,  10'd100, 10'd115,
        10'd131, 10'd146, 10'd161, 10'd176, 10'd191, 10'd206, 10'd220, 10'd234,
        10'd248, 10'd262, 10'd276, 10'd289, 10'd302, 10'd315, 10'd328, 10'd341,
        10'd354, 10'd367, 10'd379, 10'd391, 10'd403, 10'd415, 10'd427, 10'd439,
        10'd451, 10'd462, 10'd474, 10'd485, 10'd496, 10'd507, 10'd518, 10'd529,
        10'd540, 10'd550, 10'd561, 10'd571, 10'd582, 10'd592, 10'd602, 10'd612,
        10'd622, 10'd632, 10'd642, 10'd652, 10'd661, 10'd671, 10'd680, 10'd690,
        10'd699, 10'd708, 10'd717, 10'd726, 10'd735, 10'd744, 10'd753, 10'd762
    };

endpackage

`default_nettype wire

[sv/iqpd_front.sv]
`default_nettype none

module iqpd_front #(
    parameter int MAX_BLOCK = 4096,
    parameter int CW        = $clog2(MAX_BLOCK + 1),
    parameter int SW        = CW + 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    output logic                 o_full,
    input  iqpd_pkg::t_sample    i_data,
    input  wire  [12:0]          i_block_length,
    output logic                 o_q_push,
    output logic [SW+CW-1:0]     o_q_data,
    input  wire                  i_q_full
);
    import iqpd_pkg::*;

    logic                  r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [11:0]    r_i, r_q;
    logic        [22:0]    r_isq, r_qsq;
    logic        [23:0]    r_x;
    logic        [4:0]     r_p;
    logic        [5:0]     r_frac;
    logic                  r_zero;
    logic signed [15:0]    r_dbm;
    logic        [CW-1:0]  r_count;
    logic signed [SW-1:0]  r_sum;

    logic                  adv;
    logic                  blk_end;
    logic        [CW-1:0]  eff_len;
    logic        [CW-1:0]  cnt_inc;
    logic signed [SW-1:0]  sum_inc;
    logic signed [23:0]    isq_full, qsq_full;
    logic        [23:0]    x_sum;
    logic        [4:0]     lead;
    logic        [29:0]    x_ext;
    logic        [15:0]    log_u;
    logic signed [15:0]    dbm_val;

    // block length clamped to 1..MAX_BLOCK
    always_comb begin
        if (i_block_length == 13'd0) begin
            eff_len = CW'(1);
        end else if ({19'd0, i_block_length} > 32'(MAX_BLOCK)) begin
            eff_len = CW'(MAX_BLOCK);
        end else begin
            eff_len = CW'(i_block_length);
        end
    end

    assign cnt_inc = CW'({1'b0, r_count} + 1'b1);
    assign sum_inc = r_sum + {{(SW-16){r_dbm[15]}}, r_dbm};
    assign blk_end = (cnt_inc >= eff_len);
    assign adv     = !(r_v5 && blk_end && i_q_full);
    assign o_full  = !adv;

    assign o_q_push = r_v5 && blk_end && adv;
    assign o_q_data = {sum_inc, cnt_inc};

    assign isq_full = r_i * r_i;
    assign qsq_full = r_q * r_q;
    assign x_sum    = {1'b0, r_isq} + {1'b0, r_qsq};

    // leading one position
    always_comb begin
        lead = 5'd0;
        for (int k = 0; k < 24; k++) begin
            if (r_x[k]) begin
                lead = 5'(k);
            end
        end
    end
    assign x_ext = {r_x, 6'd0} >> lead;

    assign log_u   = 16'(r_p) * DB_PER_OCTAVE + {6'd0, LOGTAB[r_frac]};
    assign dbm_val = r_zero ? ZERO_POWER_DBM : $signed(log_u - DBM_OFFSET);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (adv) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            if (r_v5) begin
                if (blk_end) begin
                    r_count <= '0;
                    r_sum   <= '0;
                end else begin
                    r_count <= cnt_inc;
                    r_sum   <= sum_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_i    <= i_data.i_sample;
            r_q    <= i_data.q_sample;
            r_isq  <= isq_full[22:0];
            r_qsq  <= qsq_full[22:0];
            r_x    <= x_sum;
            r_p    <= lead;
            r_frac <= x_ext[5:0];
            r_zero <= (r_x == 24'd0);
            r_dbm  <= dbm_val;
        end
    end

endmodule

`default_nettype wire

[sv/iqpd_fifo.sv]
`default_nettype none

module iqpd_fifo #(
    parameter int WIDTH = 46
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    import iqpd_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] r_slot [QUEUE_DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

[sv/iqpd_back.sv]
`default_nettype none

module iqpd_back #(
    parameter int MAX_BLOCK = 4096,
    parameter int CW        = $clog2(MAX_BLOCK + 1),
    parameter int SW        = CW + 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire  [SW+CW-1:0]    i_q_data,
    input  wire                 i_q_empty,
    output logic                o_q_pop,
    input  wire  signed [15:0]  i_threshold,
    output logic                o_empty,
    input  wire                 i_pop,
    output iqpd_pkg::t_result   o_data
);
    import iqpd_pkg::*;

    localparam int STW = $clog2(SW);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } t_state;

    t_state            r_state;
    logic              r_neg;
    logic [SW-1:0]     r_dvd;
    logic [CW-1:0]     r_dvs;
    logic [CW-1:0]     r_rem;
    logic [STW-1:0]    r_step;
    logic              r_ov;
    t_result           r_out;

    logic signed [SW-1:0] q_sum;
    logic        [CW-1:0] q_cnt;
    logic        [CW:0]   rem_sh;
    logic        [CW:0]   rem_sub;
    logic                 q_bit;
    logic signed [15:0]   avg;
    logic                 out_free;

    assign q_sum   = i_q_data[SW+CW-1:CW];
    assign q_cnt   = i_q_data[CW-1:0];
    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    // restoring divide, one quotient bit per step
    assign rem_sh  = {r_rem, r_dvd[SW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign q_bit   = (rem_sh >= {1'b0, r_dvs});

    assign avg      = r_neg ? -$signed(r_dvd[15:0]) : $signed(r_dvd[15:0]);
    assign out_free = !r_ov || i_pop;

    assign o_empty = !r_ov;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            // in hold a popped beat is replaced by the new one below
            if (r_ov && i_pop && (r_state != S_HOLD)) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_neg   <= q_sum[SW-1];
                        r_dvd   <= q_sum[SW-1] ? SW'(-q_sum) : SW'(q_sum);
                        r_dvs   <= q_cnt;
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem  <= q_bit ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
                    r_dvd  <= {r_dvd[SW-2:0], q_bit};
                    r_step <= r_step + 1'b1;
                    if (r_step == STW'(SW - 1)) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_out.average_dbm <= avg;
                        r_out.detected    <= (avg > i_threshold);
                        r_ov              <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/iq_power_dbm_detector_top.sv]
// iq power detector: block-averaged power of 12-bit i/q pairs in 1/256 dbm
//
// input channel: a sample beat (i_sample, q_sample) is taken when push is
// high and full is low; one beat per cycle is sustained while blocks are
// longer than the divide time
// result channel: while empty is low the oldest block result (average_dbm,
// detected) sits on o_data; it is taken when pop is high and empty is low
// path: a sample passes the front pipe (register, square, sum,
// leading-one/fraction, log lookup) into the block accumulator; when it
// closes a block the sum and count enter a 4-deep queue, and the back
// divider works through one block at a time, one quotient bit a cycle,
// before the result lands in the output register
// throughput: 1 sample per cycle while full is low; with very short blocks
// the divider paces the input through full
// stall: a held result blocks the divider, the queue then fills and full
// rises only when a closing sample finds the queue full
// reset: counters, sum and queue clear, block_length 1600, threshold 1664
// config: apb writes at 0x0 (block_length) and 0x4 (detect_threshold)
`default_nettype none

module iq_power_dbm_detector_top #(
    parameter int MAX_BLOCK = 4096
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  iqpd_pkg::t_sample   i_data,
    output logic                empty,
    input  wire                 pop,
    output iqpd_pkg::t_result   o_data,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [2:0]          paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import iqpd_pkg::*;

    localparam int CW = $clog2(MAX_BLOCK + 1);
    localparam int SW = CW + 16;

    logic [12:0]        r_block_length;
    logic signed [15:0] r_threshold;
    logic               cfg_wr;

    logic               q_push, q_full, q_pop, q_empty;
    logic [SW+CW-1:0]   q_wdata, q_rdata;

    // apb: no wait states, register picked by paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= BLOCK_LENGTH_RST;
            r_threshold    <= DETECT_THRESHOLD_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_BLOCK_LENGTH:     r_block_length <= pwdata[12:0];
                REG_DETECT_THRESHOLD: r_threshold    <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BLOCK_LENGTH:     prdata = {19'd0, r_block_length};
            REG_DETECT_THRESHOLD: prdata = {{16{r_threshold[15]}}, r_threshold};
            default:              prdata = '0;
        endcase
    end

    // front: log power per sample and block accumulation
    iqpd_front #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_data         (i_data),
        .i_block_length (r_block_length),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata),
        .i_q_full       (q_full)
    );

    // finished block sums waiting for the divider
    iqpd_fifo #(
        .WIDTH (SW + CW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    // back: average by serial divide, threshold compare, output register
    iqpd_back #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (q_rdata),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_threshold (r_threshold),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_data      (o_data)
    );

endmodule

`default_nettype wire

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iqpd_pkg::*;

    // block averaging cap, passed to the block so both sides agree
    localparam int MAX_BLOCK = 4096;
    // cycles with no beat on either side before the run is abandoned
    localparam int STALL_LIMIT = 5000;
    // settle time after the last expected average, covers the front pipe
    localparam int SETTLE_CYCLES = 40;
    // percentage of cycles in which a side idles
    localparam int IDLE_PCT = 24;

    // corner codes for the sample fields: most negative, most positive, 0, -1, 1
    localparam logic [11:0] EDGE_VALS [5] = '{12'h800, 12'h7FF, 12'h000, 12'hFFF, 12'h001};

    // running block average predictor and store of expected averages
    class dbm_average_tracker;
        logic        [12:0] block_length;
        logic signed [15:0] threshold;
        int unsigned        pairs_in_block;
        longint             dbm_sum;
        t_result            pending_averages[$];
        int unsigned        mismatches;
        int unsigned        pairs_seen;
        int unsigned        averages_seen;
        int unsigned        detections;
        int unsigned        reg_writes;

        function new();
            block_length   = BLOCK_LENGTH_RST;
            threshold      = DETECT_THRESHOLD_RST;
            pairs_in_block = 0;
            dbm_sum        = 0;
            mismatches     = 0;
            pairs_seen     = 0;
            averages_seen  = 0;
            detections     = 0;
            reg_writes     = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            reg_writes++;
            if (idx == REG_BLOCK_LENGTH) begin
                block_length = value[12:0];
            end else begin
                threshold = value[15:0];
            end
        endfunction

        // q8 dbm of one pair: octave from the leading one, six bits after it index the table
        function int pair_dbm(t_sample s);
            int          si;
            int          sq;
            int unsigned x;
            int          p;
            int unsigned frac;
            si = $signed(s.i_sample);
            sq = $signed(s.q_sample);
            x  = si * si + sq * sq;
            if (x == 0) begin
                return int'(ZERO_POWER_DBM);
            end
            p = 0;
            for (int b = 0; b < 32; b++) begin
                if (x[b]) begin
                    p = b;
                end
            end
            if (p >= 6) begin
                frac = (x >> (p - 6)) & 63;
            end else begin
                frac = (x << (6 - p)) & 63;
            end
            return int'(DB_PER_OCTAVE) * p + int'(LOGTAB[frac]) - int'(DBM_OFFSET);
        endfunction

        function void take_sample(t_sample s);
            int unsigned len;
            longint      avg;
            t_result     r;
            len = block_length;
            if (len == 0) begin
                len = 1;
            end
            if (len > MAX_BLOCK) begin
                len = MAX_BLOCK;
            end
            dbm_sum += pair_dbm(s);
            pairs_in_block++;
            pairs_seen++;
            // a lowered length closes the block on the pairs already summed
            if (pairs_in_block >= len) begin
                avg           = dbm_sum / longint'(pairs_in_block);
                r.average_dbm = avg[15:0];
                r.detected    = (avg > longint'(threshold));
                pending_averages.push_back(r);
                pairs_in_block = 0;
                dbm_sum        = 0;
            end
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: %s", what);
            end
        endfunction

        function void check_average(t_result got);
            t_result want;
            averages_seen++;
            if (got.detected) begin
                detections++;
            end
            if (pending_averages.size() == 0) begin
                flag($sformatf("average %0d arrived with nothing expected (avg %0d det %0b)",
                               averages_seen, $signed(got.average_dbm), got.detected));
                return;
            end
            want = pending_averages.pop_front();
            if (got.average_dbm !== want.average_dbm || got.detected !== want.detected) begin
                flag($sformatf("average %0d expected avg %0d det %0b, got avg %0d det %0b",
                               averages_seen, $signed(want.average_dbm), want.detected,
                               $signed(got.average_dbm), got.detected));
            end
        endfunction

        function void check_leftovers();
            if (pending_averages.size() != 0) begin
                flag($sformatf("%0d expected averages never arrived", pending_averages.size()));
            end
        endfunction
    endclass

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // sample side
    logic    push   = 1'b0;
    logic    full;
    t_sample i_data = '0;

    // average side
    logic    empty;
    logic    pop    = 1'b0;
    t_result o_data;

    // register port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // when set, neither side idles
    logic steady = 1'b0;

    dbm_average_tracker tracker;
    int unsigned        quiet_cycles = 0;

    iq_power_dbm_detector_top #(
        .MAX_BLOCK(MAX_BLOCK)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // result side: check the beat taken at this edge, then pick the next pop
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                tracker.check_average(o_data);
            end
            pop <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog: any beat on either side restarts the count
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("no beat for %0d cycles, giving up", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // one sample beat, with random idle cycles ahead of it
    task automatic send_pair(input t_sample s);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_data <= s;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        tracker.take_sample(s);
    endtask

    // random pair; kmax bounds the magnitude as a power of two
    function automatic t_sample random_pair(input int kmax);
        t_sample s;
        int      k;
        case ($urandom_range(9))
            0: s = '0;
            1: begin
                s.i_sample = EDGE_VALS[$urandom_range(4)];
                s.q_sample = EDGE_VALS[$urandom_range(4)];
            end
            default: begin
                k = $urandom_range(kmax);
                s.i_sample = 12'($urandom_range((2 << k) - 1) - (1 << k));
                k = $urandom_range(kmax);
                s.q_sample = 12'($urandom_range((2 << k) - 1) - (1 << k));
            end
        endcase
        return s;
    endfunction

    task automatic send_random(input int count, input int kmax);
        for (int n = 0; n < count; n++) begin
            send_pair(random_pair(kmax));
        end
    endtask

    // stop pushing, let every expected average out, then let the front pipe empty
    task automatic wait_idle();
        push <= 1'b0;
        while (tracker.pending_averages.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write: setup beat then access beat
    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.write_reg(idx, value);
    endtask

    task automatic send_fields(input logic [11:0] i_val, input logic [11:0] q_val);
        t_sample s;
        s.i_sample = i_val;
        s.q_sample = q_val;
        send_pair(s);
    endtask

    initial begin
        int r;
        int phase;
        int count;
        tracker = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one average per pair over the corner samples
        write_reg(REG_DETECT_THRESHOLD, 32'(-4000));
        write_reg(REG_BLOCK_LENGTH, 32'd1);
        send_fields(12'd0, 12'd0);              // zero power clamp
        send_fields(12'd2047, 12'd2047);
        send_fields(12'h800, 12'h800);          // full scale, 2^23
        send_fields(12'h800, 12'd2047);
        send_fields(12'd1, 12'd0);              // smallest power
        send_fields(12'd0, 12'hFFF);
        send_fields(12'd3, 12'd4);              // leading one below six bits
        send_fields(12'hFFF, 12'hFFF);
        send_fields(12'd5, 12'd7);
        send_fields(12'd64, 12'd0);             // exact power of two
        send_fields(-12'sd1365, 12'sd1000);
        send_fields(12'd0, 12'h800);
        wait_idle();

        // detect is strictly above: full scale gives exactly 2295
        write_reg(REG_DETECT_THRESHOLD, 32'd2295);
        send_fields(12'h800, 12'h800);
        wait_idle();
        write_reg(REG_DETECT_THRESHOLD, 32'd2294);
        send_fields(12'h800, 12'h800);
        wait_idle();

        // length lowered below the pairs already summed closes the block early
        write_reg(REG_DETECT_THRESHOLD, 32'(-17920));
        write_reg(REG_BLOCK_LENGTH, 32'd20);
        send_random(7, 11);
        wait_idle();
        write_reg(REG_BLOCK_LENGTH, 32'd5);
        send_random(1, 11);
        wait_idle();

        // length zero acts as one
        write_reg(REG_DETECT_THRESHOLD, 32'd2304);
        write_reg(REG_BLOCK_LENGTH, 32'd0);
        send_random(3, 11);
        wait_idle();

        // random phases: mostly short blocks so averages come often,
        // partial blocks carry over the length changes between phases
        phase = 0;
        while (tracker.pairs_seen < 450 || tracker.averages_seen < 60) begin
            if ($urandom_range(2) == 0) begin
                r = $urandom_range(9);
                if (r == 0) begin
                    write_reg(REG_DETECT_THRESHOLD, 32'(-32768));
                end else if (r == 1) begin
                    write_reg(REG_DETECT_THRESHOLD, 32'd32767);
                end else begin
                    write_reg(REG_DETECT_THRESHOLD, 32'(int'($urandom_range(20224)) - 17920));
                end
            end
            r = $urandom_range(99);
            if (r < 60) begin
                write_reg(REG_BLOCK_LENGTH, $urandom_range(1, 16));
            end else if (r < 85) begin
                write_reg(REG_BLOCK_LENGTH, $urandom_range(17, 80));
            end else if (r < 92) begin
                write_reg(REG_BLOCK_LENGTH, 32'd0);
            end else begin
                write_reg(REG_BLOCK_LENGTH, $urandom_range(81, 300));
            end
            // one long stretch with neither side idling
            steady <= (phase == 4);
            count = (phase == 4) ? 150 : $urandom_range(1, 60);
            send_random(count, $urandom_range(11));
            wait_idle();
            phase++;
        end
        steady <= 1'b0;

        // length above the cap keeps the block open, then a lowered length
        // closes it on the pairs summed so far
        write_reg(REG_DETECT_THRESHOLD, 32'(-3000));
        write_reg(REG_BLOCK_LENGTH, 32'h1FFF);
        send_random(40, 11);
        wait_idle();
        write_reg(REG_BLOCK_LENGTH, 32'd1);
        send_random(1, 8);
        wait_idle();

        tracker.check_leftovers();
        $display("run covered %0d sample pairs over %0d phases, %0d block averages (%0d detected)",
                 tracker.pairs_seen, phase, tracker.averages_seen, tracker.detections);
        $display("register writes %0d, mismatches %0d", tracker.reg_writes, tracker.mismatches);
        if (tracker.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
